// File: hw/rtl/ddssc_pkg.sv
// ---------------------------------------------------------------------------
// Differential drive speed and steering control package
// Shared widths, register indexes, state codes and the pulse and duty tables.
// ---------------------------------------------------------------------------
package ddssc_pkg;

    // Parameter defaults
    localparam int COUNT_WIDTH_DEF      = 32;
    localparam int SAMPLE_PERIOD_MS_DEF = 100;

    // Port field widths
    localparam int COUNT_FIELD_W = 32;
    localparam int SPEED_W       = 32;
    localparam int CMD_W         = 8;
    localparam int PULSE_W       = 11;
    localparam int DUTY_W        = 13;

    // Configuration register widths and port shape
    localparam int TGT_W      = 14;
    localparam int PCT_W      = 7;
    localparam int DIV_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_COMMAND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COMMAND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_DIVISOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LIMIT     = 3'd6;

    localparam logic [TGT_W-1:0] RST_TARGET_SPEED    = 14'd250;
    localparam logic [TGT_W-1:0] RST_SPEED_TOLERANCE = 14'd10;
    localparam logic [PCT_W-1:0] RST_COMMAND_STEP    = 7'd2;
    localparam logic [PCT_W-1:0] RST_INITIAL_COMMAND = 7'd20;
    localparam logic [PCT_W-1:0] RST_MAX_COMMAND     = 7'd80;
    localparam logic [DIV_W-1:0] RST_STEER_DIVISOR   = 10'd40;
    localparam logic [PCT_W-1:0] RST_STEER_LIMIT     = 7'd25;

    // Speed scaling: ticks per period times MS_PER_S, one multiplier bit per window tap
    localparam int MS_PER_S = 1000;
    localparam int MUL_W    = $clog2(MS_PER_S + 1);
    localparam logic [MUL_W-1:0] MS_PER_S_BITS = MUL_W'(MS_PER_S);
    localparam int SUM_W    = $clog2(2 * MUL_W + 1);

    // Servo mapping
    localparam int PCT_LIMIT = 100;
    localparam int PULSE_MID = 1500;
    localparam int PULSE_LO  = 1100;
    localparam int PULSE_HI  = 1900;
    localparam int PERIOD_US = 20000;
    localparam int DUTY_FULL = ((1 << 16) - 1);

    localparam int LUT_N = 2 * PCT_LIMIT + 1;

    typedef logic [LUT_N-1:0][PULSE_W-1:0] pulse_lut_t;
    typedef logic [LUT_N-1:0][DUTY_W-1:0]  duty_lut_t;

    function automatic int pulse_of(int pct);
        if (pct >= 0) begin
            return PULSE_MID + ((PULSE_HI - PULSE_MID) * pct) / PCT_LIMIT;
        end
        return PULSE_MID + ((PULSE_MID - PULSE_LO) * pct) / PCT_LIMIT;
    endfunction

    function automatic pulse_lut_t build_pulse_lut();
        pulse_lut_t lut;
        for (int i = 0; i < LUT_N; i++) begin
            lut[i] = PULSE_W'(pulse_of(i - PCT_LIMIT));
        end
        return lut;
    endfunction

    function automatic duty_lut_t build_duty_lut();
        duty_lut_t lut;
        for (int i = 0; i < LUT_N; i++) begin
            lut[i] = DUTY_W'((pulse_of(i - PCT_LIMIT) * DUTY_FULL) / PERIOD_US);
        end
        return lut;
    endfunction

    // Both tables are indexed by the percent plus PCT_LIMIT.
    localparam pulse_lut_t PULSE_LUT = build_pulse_lut();
    localparam duty_lut_t  DUTY_LUT  = build_duty_lut();

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_SPEED = 9'b000010000,
        S_BASE  = 9'b000100000,
        S_STEER = 9'b001000000,
        S_CMD   = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

endpackage

// File: hw/rtl/differential_drive_speed_steer_control.sv
// ---------------------------------------------------------------------------
// Differential drive speed and steering control
// Wheel speed measurement, base command stepping, straight-line steering and
// servo pulse and duty mapping for one encoder sample per control period.
// ---------------------------------------------------------------------------
// One encoder sample is taken per transfer and one result transfer follows it.
// The block works on one sample at a time, and a rebase item skips the steering
// steps. The work is done by a bit-serial datapath: both wheels run side by side
// through a constant multiplier by 1000 and a restoring divider, and the steering
// term then reuses the left divider lane. A new sample is taken as soon as the
// block is back in idle, even while the previous result still waits in the
// output register.
module differential_drive_speed_steer_control #(
    parameter int COUNT_WIDTH      = ddssc_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_PERIOD_MS = ddssc_pkg::SAMPLE_PERIOD_MS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ddssc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddssc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // Sample input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,  // left_count, right_count
    input  logic                                s_tuser,  // rebase
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // left_command, right_command, left_pulse_width, right_pulse_width,
    // left_duty, right_duty, left_speed, right_speed
    output logic [127:0]                        m_tdata
);

    localparam int W      = COUNT_WIDTH;
    localparam int PROD_W = W + ddssc_pkg::MUL_W;
    localparam int QX_W   = (PROD_W > ddssc_pkg::SPEED_W) ? PROD_W : ddssc_pkg::SPEED_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int ERR_W  = ddssc_pkg::SPEED_W + 2;
    localparam int CW9    = ddssc_pkg::CMD_W + 1;
    localparam int DIV_W  = ddssc_pkg::DIV_W;
    localparam int PCT_W  = ddssc_pkg::PCT_W;
    localparam int CMD_W  = ddssc_pkg::CMD_W;
    localparam int SPD_W  = ddssc_pkg::SPEED_W;
    localparam int CRY_W  = ddssc_pkg::SUM_W - 1;

    function automatic logic [PCT_W-1:0] cap_pct(logic [PCT_W-1:0] v);
        return (v > PCT_W'(ddssc_pkg::PCT_LIMIT)) ? PCT_W'(ddssc_pkg::PCT_LIMIT) : v;
    endfunction

    // Control state
    ddssc_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [ddssc_pkg::TGT_W-1:0] target_reg, target_next;
    logic [ddssc_pkg::TGT_W-1:0] tol_reg, tol_next;
    logic [PCT_W-1:0]            step_reg, step_next;
    logic [PCT_W-1:0]            init_reg, init_next;
    logic [PCT_W-1:0]            max_reg, max_next;
    logic [DIV_W-1:0]            sdiv_reg, sdiv_next;
    logic [PCT_W-1:0]            slim_reg, slim_next;

    logic [W-1:0]              prev_reg [2];
    logic [W-1:0]              prev_next [2];
    logic [W-1:0]              start_reg [2];
    logic [W-1:0]              start_next [2];
    logic signed [CMD_W-1:0]   base_reg [2];
    logic signed [CMD_W-1:0]   base_next [2];

    // Datapath (lane 0 is the left wheel, lane 1 the right)
    logic                      rebase_reg, rebase_next;
    logic [W-1:0]              cur_reg [2];
    logic [W-1:0]              cur_next [2];
    logic [W-1:0]              dist_reg [2];
    logic [W-1:0]              dist_next [2];
    logic                      neg_reg [2];
    logic                      neg_next [2];
    logic [W-1:0]              mcand_reg [2];
    logic [W-1:0]              mcand_next [2];
    logic [ddssc_pkg::MUL_W-1:0] win_reg [2];
    logic [ddssc_pkg::MUL_W-1:0] win_next [2];
    logic [CRY_W-1:0]          carry_reg [2];
    logic [CRY_W-1:0]          carry_next [2];
    logic [PROD_W-1:0]         dvd_reg [2];
    logic [PROD_W-1:0]         dvd_next [2];
    logic [DIV_W-1:0]          rem_reg [2];
    logic [DIV_W-1:0]          rem_next [2];
    logic [DIV_W-1:0]          div_reg, div_next;
    logic                      steer_neg_reg, steer_neg_next;
    logic signed [SPD_W-1:0]   speed_reg [2];
    logic signed [SPD_W-1:0]   speed_next [2];
    logic signed [CMD_W-1:0]   cmd_reg [2];
    logic signed [CMD_W-1:0]   cmd_next [2];
    logic [127:0]              m_tdata_reg, m_tdata_next;

    // Per-lane serial step results
    logic [ddssc_pkg::MUL_W-1:0] mul_win [2];
    logic [ddssc_pkg::SUM_W-1:0] mul_sum [2];
    logic [DIV_W:0]              div_t [2];
    logic                        div_ge [2];
    logic [DIV_W-1:0]            div_rem [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            mul_win[i] = {win_reg[i][ddssc_pkg::MUL_W-2:0], mcand_reg[i][0]};
            mul_sum[i] = ddssc_pkg::SUM_W'($countones(mul_win[i] & ddssc_pkg::MS_PER_S_BITS))
                       + ddssc_pkg::SUM_W'(carry_reg[i]);
            div_t[i]   = {rem_reg[i], dvd_reg[i][PROD_W-1]};
            div_ge[i]  = (div_t[i] >= {1'b0, div_reg});
            div_rem[i] = div_ge[i] ? DIV_W'(div_t[i] - {1'b0, div_reg}) : div_t[i][DIV_W-1:0];
        end
    end

    assign s_tready = (state_reg == ddssc_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        logic [W-1:0]              diff;
        logic [QX_W-1:0]           qx;
        logic                      sat;
        logic [SPD_W-2:0]          mag;
        logic [W:0]                dsum;
        logic [W:0]                dmag;
        logic [PCT_W-1:0]          mx;
        logic signed [ERR_W-1:0]   tgt_x;
        logic signed [ERR_W-1:0]   spd_x;
        logic signed [ERR_W-1:0]   err;
        logic [ERR_W-1:0]          err_mag;
        logic signed [CW9-1:0]     b9;
        logic signed [CW9-1:0]     mx9;
        logic signed [CW9-1:0]     steer9;
        logic signed [CW9-1:0]     c9;
        logic [PCT_W-1:0]          steer_mag;
        logic [CMD_W-1:0]          idx_l;
        logic [CMD_W-1:0]          idx_r;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        target_next    = target_reg;
        tol_next       = tol_reg;
        step_next      = step_reg;
        init_next      = init_reg;
        max_next       = max_reg;
        sdiv_next      = sdiv_reg;
        slim_next      = slim_reg;
        rebase_next    = rebase_reg;
        div_next       = div_reg;
        steer_neg_next = steer_neg_reg;
        m_tdata_next   = m_tdata_reg;
        for (int i = 0; i < 2; i++) begin
            prev_next[i]  = prev_reg[i];
            start_next[i] = start_reg[i];
            base_next[i]  = base_reg[i];
            cur_next[i]   = cur_reg[i];
            dist_next[i]  = dist_reg[i];
            neg_next[i]   = neg_reg[i];
            mcand_next[i] = mcand_reg[i];
            win_next[i]   = win_reg[i];
            carry_next[i] = carry_reg[i];
            dvd_next[i]   = dvd_reg[i];
            rem_next[i]   = rem_reg[i];
            speed_next[i] = speed_reg[i];
            cmd_next[i]   = cmd_reg[i];
        end

        mx      = cap_pct(max_reg);
        mx9     = -CW9'(mx);
        mx9     = -mx9;
        tgt_x   = ERR_W'(target_reg);
        diff    = '0;
        qx      = '0;
        sat     = 1'b0;
        mag     = '0;
        dsum    = '0;
        dmag    = '0;
        spd_x   = '0;
        err     = '0;
        err_mag = '0;
        b9      = '0;
        steer9  = '0;
        c9      = '0;
        steer_mag = '0;
        idx_l   = '0;
        idx_r   = '0;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                ddssc_pkg::REG_TARGET_SPEED:    target_next = cfg_wdata;
                ddssc_pkg::REG_SPEED_TOLERANCE: tol_next    = cfg_wdata;
                ddssc_pkg::REG_COMMAND_STEP:    step_next   = cfg_wdata[PCT_W-1:0];
                ddssc_pkg::REG_INITIAL_COMMAND: init_next   = cfg_wdata[PCT_W-1:0];
                ddssc_pkg::REG_MAX_COMMAND:     max_next    = cfg_wdata[PCT_W-1:0];
                ddssc_pkg::REG_STEER_DIVISOR:   sdiv_next   = cfg_wdata[DIV_W-1:0];
                ddssc_pkg::REG_STEER_LIMIT:     slim_next   = cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ddssc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    rebase_next = s_tuser;
                    cur_next[0] = s_tdata[W-1:0];
                    cur_next[1] = s_tdata[ddssc_pkg::COUNT_FIELD_W +: W];
                    state_next  = ddssc_pkg::S_PREP;
                end
            end
            ddssc_pkg::S_PREP: begin
                for (int i = 0; i < 2; i++) begin
                    diff          = cur_reg[i] - prev_reg[i];
                    neg_next[i]   = diff[W-1];
                    mcand_next[i] = diff[W-1] ? -diff : diff;
                    prev_next[i]  = cur_reg[i];
                    dist_next[i]  = cur_reg[i] - start_reg[i];
                    win_next[i]   = '0;
                    carry_next[i] = '0;
                    if (rebase_reg) begin
                        start_next[i] = cur_reg[i];
                    end
                end
                if (rebase_reg) begin
                    base_next[0] = -CMD_W'(cap_pct(init_reg));
                    base_next[1] = CMD_W'(cap_pct(init_reg));
                end
                cnt_next   = '0;
                state_next = ddssc_pkg::S_MUL;
            end
            ddssc_pkg::S_MUL: begin
                // Product bits come out LSB first and fill the divider register from the top.
                for (int i = 0; i < 2; i++) begin
                    win_next[i]   = mul_win[i];
                    carry_next[i] = mul_sum[i][ddssc_pkg::SUM_W-1:1];
                    mcand_next[i] = mcand_reg[i] >> 1;
                    dvd_next[i]   = {mul_sum[i][0], dvd_reg[i][PROD_W-1:1]};
                    rem_next[i]   = '0;
                end
                div_next = DIV_W'(SAMPLE_PERIOD_MS);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ddssc_pkg::S_DIV;
                end
            end
            ddssc_pkg::S_DIV: begin
                for (int i = 0; i < 2; i++) begin
                    rem_next[i] = div_rem[i];
                    dvd_next[i] = {dvd_reg[i][PROD_W-2:0], div_ge[i]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                    cnt_next   = '0;
                    state_next = ddssc_pkg::S_SPEED;
                end
            end
            ddssc_pkg::S_SPEED: begin
                for (int i = 0; i < 2; i++) begin
                    qx  = QX_W'(dvd_reg[i]);
                    sat = |qx[QX_W-1:SPD_W-1];
                    mag = sat ? {(SPD_W-1){1'b1}} : qx[SPD_W-2:0];
                    speed_next[i] = neg_reg[i] ? -{1'b0, mag} : {1'b0, mag};
                end
                if (rebase_reg) begin
                    cmd_next[0] = '0;
                    cmd_next[1] = '0;
                    state_next  = ddssc_pkg::S_FIN;
                end else begin
                    state_next  = ddssc_pkg::S_BASE;
                end
            end
            ddssc_pkg::S_BASE: begin
                // The left wheel chases minus the target and stays in [-max, 0].
                for (int i = 0; i < 2; i++) begin
                    spd_x   = ERR_W'(speed_reg[i]);
                    err     = (i == 0) ? (-tgt_x - spd_x) : (tgt_x - spd_x);
                    err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
                    b9      = CW9'(base_reg[i]);
                    if (err_mag > ERR_W'(tol_reg)) begin
                        b9 = err[ERR_W-1] ? (b9 - CW9'(step_reg)) : (b9 + CW9'(step_reg));
                    end
                    if (i == 0) begin
                        if (b9 > 0) begin
                            b9 = '0;
                        end else if (b9 < -mx9) begin
                            b9 = -mx9;
                        end
                    end else begin
                        if (b9 > mx9) begin
                            b9 = mx9;
                        end else if (b9 < 0) begin
                            b9 = '0;
                        end
                    end
                    base_next[i] = CMD_W'(b9);
                end
                // Distance difference is minus the sum of both travelled counts.
                dsum = {dist_reg[0][W-1], dist_reg[0]} + {dist_reg[1][W-1], dist_reg[1]};
                dmag = dsum[W] ? -dsum : dsum;
                steer_neg_next = !dsum[W] && (dsum != '0);
                dvd_next[0] = PROD_W'(dmag) << (PROD_W - W - 1);
                rem_next[0] = '0;
                div_next    = (sdiv_reg == '0) ? DIV_W'(1) : sdiv_reg;
                cnt_next    = '0;
                state_next  = ddssc_pkg::S_STEER;
            end
            ddssc_pkg::S_STEER: begin
                rem_next[0] = div_rem[0];
                dvd_next[0] = {dvd_reg[0][PROD_W-2:0], div_ge[0]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(W)) begin
                    cnt_next   = '0;
                    state_next = ddssc_pkg::S_CMD;
                end
            end
            ddssc_pkg::S_CMD: begin
                steer_mag = (dvd_reg[0] > PROD_W'(slim_reg)) ? slim_reg : dvd_reg[0][PCT_W-1:0];
                steer9    = steer_neg_reg ? -CW9'(steer_mag) : CW9'(steer_mag);
                for (int i = 0; i < 2; i++) begin
                    c9 = (i == 0) ? (CW9'(base_reg[i]) - steer9) : (CW9'(base_reg[i]) + steer9);
                    if (c9 > mx9) begin
                        c9 = mx9;
                    end else if (c9 < -mx9) begin
                        c9 = -mx9;
                    end
                    cmd_next[i] = CMD_W'(c9);
                end
                state_next = ddssc_pkg::S_FIN;
            end
            ddssc_pkg::S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    idx_l = CMD_W'(cmd_reg[0]) + CMD_W'(ddssc_pkg::PCT_LIMIT);
                    idx_r = CMD_W'(cmd_reg[1]) + CMD_W'(ddssc_pkg::PCT_LIMIT);
                    m_tdata_next = {speed_reg[1], speed_reg[0],
                                    ddssc_pkg::DUTY_LUT[idx_r], ddssc_pkg::DUTY_LUT[idx_l],
                                    ddssc_pkg::PULSE_LUT[idx_r], ddssc_pkg::PULSE_LUT[idx_l],
                                    cmd_reg[1], cmd_reg[0]};
                    m_tvalid_next = 1'b1;
                    state_next    = ddssc_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ddssc_pkg::S_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ddssc_pkg::S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            target_reg   <= ddssc_pkg::RST_TARGET_SPEED;
            tol_reg      <= ddssc_pkg::RST_SPEED_TOLERANCE;
            step_reg     <= ddssc_pkg::RST_COMMAND_STEP;
            init_reg     <= ddssc_pkg::RST_INITIAL_COMMAND;
            max_reg      <= ddssc_pkg::RST_MAX_COMMAND;
            sdiv_reg     <= ddssc_pkg::RST_STEER_DIVISOR;
            slim_reg     <= ddssc_pkg::RST_STEER_LIMIT;
            base_reg[0]  <= -CMD_W'(ddssc_pkg::RST_INITIAL_COMMAND);
            base_reg[1]  <= CMD_W'(ddssc_pkg::RST_INITIAL_COMMAND);
            for (int i = 0; i < 2; i++) begin
                prev_reg[i]  <= '0;
                start_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            target_reg   <= target_next;
            tol_reg      <= tol_next;
            step_reg     <= step_next;
            init_reg     <= init_next;
            max_reg      <= max_next;
            sdiv_reg     <= sdiv_next;
            slim_reg     <= slim_next;
            for (int i = 0; i < 2; i++) begin
                base_reg[i]  <= base_next[i];
                prev_reg[i]  <= prev_next[i];
                start_reg[i] <= start_next[i];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rebase_reg    <= rebase_next;
        div_reg       <= div_next;
        steer_neg_reg <= steer_neg_next;
        m_tdata_reg   <= m_tdata_next;
        for (int i = 0; i < 2; i++) begin
            cur_reg[i]   <= cur_next[i];
            dist_reg[i]  <= dist_next[i];
            neg_reg[i]   <= neg_next[i];
            mcand_reg[i] <= mcand_next[i];
            win_reg[i]   <= win_next[i];
            carry_reg[i] <= carry_next[i];
            dvd_reg[i]   <= dvd_next[i];
            rem_reg[i]   <= rem_next[i];
            speed_reg[i] <= speed_next[i];
            cmd_reg[i]   <= cmd_next[i];
        end
    end

    // A result is only ever offered straight out of the finishing state.
    a_out_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ddssc_pkg::S_FIN))
        else $error("result offered outside the finishing state");

    // Only one sample is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample taken while one is in flight");

    // A rebase result is neutral on both wheels.
    a_rebase_neutral: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid) && rebase_reg) |-> (m_tdata[15:0] == 16'd0))
        else $error("rebase result is not neutral");

    // Final percents never leave the servo range.
    a_cmd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (($signed(m_tdata[7:0]) <= 8'sd100) && ($signed(m_tdata[7:0]) >= -8'sd100)
                   && ($signed(m_tdata[15:8]) <= 8'sd100) && ($signed(m_tdata[15:8]) >= -8'sd100)))
        else $error("command percent out of range");

endmodule
